// ===== src/ohp_pkg.sv =====
// ----------------------------------------------------------------------------
// ohp_pkg
// Shared types, widths and constants of the oversampled ADC to pH converter.
// ----------------------------------------------------------------------------
package ohp_pkg;

  // Defaults of the top-level parameters.
  localparam int SAMPLES_PER_READING_DEF = 16;
  localparam int ADC_FULL_SCALE_DEF      = 4095;

  // Field and register widths.
  localparam int CODE_W  = 12;
  localparam int SUM_W   = 22;
  localparam int CNT_W   = 7;
  localparam int FS_W    = 16;
  localparam int REF_W   = 13;
  localparam int NERN_W  = 17;
  localparam int Q16_W   = 24;
  localparam int VOLT_W  = 23;
  localparam int MINV_W  = 7;

  // Datapath widths of the back end.
  localparam int MV_W    = 10;
  localparam int P1_W    = SUM_W + REF_W;
  localparam int NUM_W   = P1_W + MV_W;
  localparam int DEN_W   = CNT_W + FS_W;
  // The average code never exceeds 4095 and the full scale is at least 255,
  // so the voltage quotient stays below 2**27; one spare bit keeps it even.
  localparam int VQ_W    = 28;
  localparam int DELTA_W = VQ_W + 1;
  localparam int PROD_W  = DELTA_W + Q16_W;
  localparam int MAG_W   = PROD_W - 1;
  localparam int PHW_W   = PROD_W + 1;
  localparam int STEP_W  = 5;
  localparam int VDIV_STEPS = VQ_W / 2;
  localparam int NDIV_STEPS = MAG_W / 2;

  localparam logic [MV_W-1:0]    MV_TO_UV      = MV_W'(1000);
  localparam logic [DELTA_W-1:0] MID_SUPPLY_UV = DELTA_W'(1650000);
  localparam logic [VOLT_W-1:0]  VOLT_MAX      = {VOLT_W{1'b1}};

  // Register reset values.
  localparam logic [Q16_W-1:0]  PH_OFFSET_RST = Q16_W'(458752);
  localparam logic [Q16_W-1:0]  PH_SLOPE_RST  = Q16_W'(65536);
  localparam logic [NERN_W-1:0] NERNST_RST    = NERN_W'(59160);
  localparam logic [REF_W-1:0]  REFERENCE_RST = REF_W'(3300);
  localparam logic [MINV_W-1:0] MIN_VALID_RST = MINV_W'(12);

  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_PH_OFFSET = 3'd0,
    REG_PH_SLOPE  = 3'd1,
    REG_NERNST    = 3'd2,
    REG_REFERENCE = 3'd3,
    REG_MIN_VALID = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [CODE_W-1:0] adc_sample;
    logic              sample_ok;
  } sample_t;

  typedef struct packed {
    logic                     status;
    logic signed [Q16_W-1:0]  ph_value_q16;
    logic [VOLT_W-1:0]        voltage_uv;
  } reading_t;

  typedef struct packed {
    logic signed [Q16_W-1:0] ph_offset_q16;
    logic signed [Q16_W-1:0] ph_slope_q16;
    logic [NERN_W-1:0]       nernst_uv_per_ph;
    logic [REF_W-1:0]        reference_mv;
    logic [MINV_W-1:0]       min_valid;
  } cfg_t;

  // One finished burst as handed from the front end to the back end.
  typedef struct packed {
    logic             fail;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } burst_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_REF,
    BK_MUL_K,
    BK_DIV_VOLT,
    BK_DELTA,
    BK_MUL_SLOPE,
    BK_ABS,
    BK_DIV_NERN,
    BK_OFFSET,
    BK_DONE
  } back_state_t;

endpackage

// ===== src/ohp_chan_if.sv =====
// ----------------------------------------------------------------------------
// ohp_chan_if
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface ohp_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ohp_front.sv =====
// ----------------------------------------------------------------------------
// ohp_front
// Accumulates valid samples over a burst and classifies the finished burst.
// ----------------------------------------------------------------------------
module ohp_front #(
  parameter int SAMPLES_PER_READING = ohp_pkg::SAMPLES_PER_READING_DEF
) (
  input  logic              clk,
  input  logic              rst,
  ohp_chan_if.sink          sample_in,
  input  ohp_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              push,
  output ohp_pkg::burst_t   push_data
);

  localparam int POS_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(SAMPLES_PER_READING - 1);

  logic [ohp_pkg::SUM_W-1:0] sample_sum;
  logic [ohp_pkg::CNT_W-1:0] valid_count;
  logic [POS_W-1:0]          burst_position;

  logic [ohp_pkg::SUM_W-1:0] sum_next;
  logic [ohp_pkg::CNT_W-1:0] count_next;
  logic                      last;
  logic                      accept;

  assign last   = (burst_position == LAST_POS);
  // The last sample of a burst waits only when the queue has no room.
  assign sample_in.ready = !last || !q_full;
  assign accept = sample_in.valid && sample_in.ready;

  always_comb begin
    sum_next   = sample_sum;
    count_next = valid_count;
    if (sample_in.data.sample_ok) begin
      sum_next   = sample_sum + ohp_pkg::SUM_W'(sample_in.data.adc_sample);
      count_next = valid_count + ohp_pkg::CNT_W'(1);
    end
  end

  assign push           = accept && last;
  assign push_data.sum  = sum_next;
  assign push_data.cnt  = count_next;
  assign push_data.fail = (count_next == '0) || (count_next < cfg.min_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum     <= '0;
      valid_count    <= '0;
      burst_position <= '0;
    end else if (accept) begin
      if (last) begin
        sample_sum     <= '0;
        valid_count    <= '0;
        burst_position <= '0;
      end else begin
        sample_sum     <= sum_next;
        valid_count    <= count_next;
        burst_position <= burst_position + POS_W'(1);
      end
    end
  end

endmodule

// ===== src/ohp_queue.sv =====
// ----------------------------------------------------------------------------
// ohp_queue
// Short first-in first-out queue of finished bursts between front and back.
// ----------------------------------------------------------------------------
module ohp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ohp_pkg::burst_t   push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ohp_pkg::burst_t   head_data
);

  localparam int PTR_W = (ohp_pkg::QUEUE_DEPTH > 1) ? $clog2(ohp_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ohp_pkg::QUEUE_DEPTH + 1);

  ohp_pkg::burst_t  entry [ohp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full       = (fill == CNT_W'(ohp_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(ohp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(ohp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/ohp_back.sv =====
// ----------------------------------------------------------------------------
// ohp_back
// Turns one burst into a reading: voltage division, slope multiply, Nernst
// division, offset and saturation, then holds the reading in an output register.
// ----------------------------------------------------------------------------
module ohp_back #(
  parameter int ADC_FULL_SCALE = ohp_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ohp_pkg::cfg_t     cfg,
  input  logic              head_valid,
  input  ohp_pkg::burst_t   head_data,
  output logic              pop,
  ohp_chan_if.source        reading_out
);

  localparam logic [ohp_pkg::FS_W-1:0] FULL_SCALE = ohp_pkg::FS_W'(ADC_FULL_SCALE);

  ohp_pkg::back_state_t state, state_next;

  logic                              fail_r;
  logic [ohp_pkg::SUM_W-1:0]         sum_r;
  logic [ohp_pkg::CNT_W-1:0]         cnt_r;
  logic [ohp_pkg::P1_W-1:0]          prod_ref;
  logic [ohp_pkg::DEN_W-1:0]         den_r;
  logic [ohp_pkg::DEN_W-1:0]         rem_v;
  logic [ohp_pkg::VQ_W-1:0]          dq_v;
  logic signed [ohp_pkg::DELTA_W-1:0] delta_r;
  logic signed [ohp_pkg::PROD_W-1:0] prod_s;
  logic                              neg_r;
  logic [ohp_pkg::NERN_W-1:0]        rem_n;
  logic [ohp_pkg::MAG_W-1:0]         dq_n;
  logic signed [ohp_pkg::PHW_W-1:0]  ph_wide;
  logic [ohp_pkg::STEP_W-1:0]        step;

  logic                              out_valid;
  ohp_pkg::reading_t                 out_data;
  logic                              load_out;

  logic [ohp_pkg::NUM_W-1:0]         num_k;
  logic [ohp_pkg::DEN_W:0]           va, vb;
  logic                              vqa, vqb;
  logic [ohp_pkg::NERN_W-1:0]        nern_eff;
  logic [ohp_pkg::NERN_W:0]          na, nb;
  logic                              nqa, nqb;
  logic signed [ohp_pkg::PROD_W-1:0] term;
  logic signed [ohp_pkg::PHW_W-1:0]  ph_sum;
  logic signed [ohp_pkg::Q16_W-1:0]  ph_sat;
  logic [ohp_pkg::VOLT_W-1:0]        volt_sat;

  assign reading_out.valid = out_valid;
  assign reading_out.data  = out_data;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ohp_pkg::BK_IDLE: begin
        if (head_valid) begin
          state_next = head_data.fail ? ohp_pkg::BK_DONE : ohp_pkg::BK_MUL_REF;
        end
      end
      ohp_pkg::BK_MUL_REF:   state_next = ohp_pkg::BK_MUL_K;
      ohp_pkg::BK_MUL_K:     state_next = ohp_pkg::BK_DIV_VOLT;
      ohp_pkg::BK_DIV_VOLT: begin
        if (step == '0) begin
          state_next = ohp_pkg::BK_DELTA;
        end
      end
      ohp_pkg::BK_DELTA:     state_next = ohp_pkg::BK_MUL_SLOPE;
      ohp_pkg::BK_MUL_SLOPE: state_next = ohp_pkg::BK_ABS;
      ohp_pkg::BK_ABS:       state_next = ohp_pkg::BK_DIV_NERN;
      ohp_pkg::BK_DIV_NERN: begin
        if (step == '0) begin
          state_next = ohp_pkg::BK_OFFSET;
        end
      end
      ohp_pkg::BK_OFFSET:    state_next = ohp_pkg::BK_DONE;
      ohp_pkg::BK_DONE: begin
        if (!out_valid || reading_out.ready) begin
          state_next = ohp_pkg::BK_IDLE;
        end
      end
      default:               state_next = ohp_pkg::BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ohp_pkg::BK_IDLE: pop      = head_valid;
      ohp_pkg::BK_DONE: load_out = !out_valid || reading_out.ready;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // Two restoring division steps per cycle for each divider.
  always_comb begin
    num_k = ohp_pkg::NUM_W'(prod_ref) * ohp_pkg::NUM_W'(ohp_pkg::MV_TO_UV);

    va  = {rem_v, dq_v[ohp_pkg::VQ_W-1]};
    vqa = (va >= {1'b0, den_r});
    if (vqa) begin
      va = va - {1'b0, den_r};
    end
    vb  = {va[ohp_pkg::DEN_W-1:0], dq_v[ohp_pkg::VQ_W-2]};
    vqb = (vb >= {1'b0, den_r});
    if (vqb) begin
      vb = vb - {1'b0, den_r};
    end

    nern_eff = (cfg.nernst_uv_per_ph == '0) ? ohp_pkg::NERN_W'(1) : cfg.nernst_uv_per_ph;
    na  = {rem_n, dq_n[ohp_pkg::MAG_W-1]};
    nqa = (na >= {1'b0, nern_eff});
    if (nqa) begin
      na = na - {1'b0, nern_eff};
    end
    nb  = {na[ohp_pkg::NERN_W-1:0], dq_n[ohp_pkg::MAG_W-2]};
    nqb = (nb >= {1'b0, nern_eff});
    if (nqb) begin
      nb = nb - {1'b0, nern_eff};
    end

    term   = neg_r ? -$signed({1'b0, dq_n}) : $signed({1'b0, dq_n});
    ph_sum = $signed({{(ohp_pkg::PHW_W - ohp_pkg::Q16_W){cfg.ph_offset_q16[ohp_pkg::Q16_W-1]}},
                      cfg.ph_offset_q16})
           + $signed({term[ohp_pkg::PROD_W-1], term});

    if (ph_wide > $signed(ohp_pkg::PHW_W'({1'b0, {(ohp_pkg::Q16_W-1){1'b1}}}))) begin
      ph_sat = {1'b0, {(ohp_pkg::Q16_W-1){1'b1}}};
    end else if (ph_wide < $signed({{(ohp_pkg::PHW_W-ohp_pkg::Q16_W+1){1'b1}},
                                    {(ohp_pkg::Q16_W-1){1'b0}}})) begin
      ph_sat = {1'b1, {(ohp_pkg::Q16_W-1){1'b0}}};
    end else begin
      ph_sat = ph_wide[ohp_pkg::Q16_W-1:0];
    end

    if (dq_v > ohp_pkg::VQ_W'(ohp_pkg::VOLT_MAX)) begin
      volt_sat = ohp_pkg::VOLT_MAX;
    end else begin
      volt_sat = dq_v[ohp_pkg::VOLT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ohp_pkg::BK_IDLE: begin
        fail_r <= head_data.fail;
        sum_r  <= head_data.sum;
        cnt_r  <= head_data.cnt;
      end
      ohp_pkg::BK_MUL_REF: begin
        prod_ref <= ohp_pkg::P1_W'(sum_r) * ohp_pkg::P1_W'(cfg.reference_mv);
        den_r    <= ohp_pkg::DEN_W'(cnt_r) * ohp_pkg::DEN_W'(FULL_SCALE);
      end
      ohp_pkg::BK_MUL_K: begin
        // The top bits are already below the divisor since the quotient fits VQ_W bits.
        rem_v <= ohp_pkg::DEN_W'(num_k[ohp_pkg::NUM_W-1:ohp_pkg::VQ_W]);
        dq_v  <= num_k[ohp_pkg::VQ_W-1:0];
        step  <= ohp_pkg::STEP_W'(ohp_pkg::VDIV_STEPS - 1);
      end
      ohp_pkg::BK_DIV_VOLT: begin
        rem_v <= vb[ohp_pkg::DEN_W-1:0];
        dq_v  <= {dq_v[ohp_pkg::VQ_W-3:0], vqa, vqb};
        step  <= step - ohp_pkg::STEP_W'(1);
      end
      ohp_pkg::BK_DELTA: begin
        delta_r <= $signed(ohp_pkg::MID_SUPPLY_UV) - $signed({1'b0, dq_v});
      end
      ohp_pkg::BK_MUL_SLOPE: begin
        prod_s <= delta_r * cfg.ph_slope_q16;
      end
      ohp_pkg::BK_ABS: begin
        neg_r <= prod_s[ohp_pkg::PROD_W-1];
        dq_n  <= prod_s[ohp_pkg::PROD_W-1] ? ohp_pkg::MAG_W'(-prod_s)
                                           : ohp_pkg::MAG_W'(prod_s);
        rem_n <= '0;
        step  <= ohp_pkg::STEP_W'(ohp_pkg::NDIV_STEPS - 1);
      end
      ohp_pkg::BK_DIV_NERN: begin
        rem_n <= nb[ohp_pkg::NERN_W-1:0];
        dq_n  <= {dq_n[ohp_pkg::MAG_W-3:0], nqa, nqb};
        step  <= step - ohp_pkg::STEP_W'(1);
      end
      ohp_pkg::BK_OFFSET: begin
        ph_wide <= ph_sum;
      end
      ohp_pkg::BK_DONE: begin
        if (load_out) begin
          if (fail_r) begin
            out_data <= '{status: 1'b1, ph_value_q16: '0, voltage_uv: '0};
          end else begin
            out_data <= '{status: 1'b0, ph_value_q16: ph_sat, voltage_uv: volt_sat};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ohp_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (reading_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/oversampled_adc_to_ph_core.sv =====
// ----------------------------------------------------------------------------
// oversampled_adc_to_ph_core
// Averages bursts of ADC samples and converts each burst to a pH reading.
// ----------------------------------------------------------------------------
// The block takes one ADC sample per clock while it is not stalled and gives
// one reading at the end of each burst of SAMPLES_PER_READING samples.
// Finished bursts wait in a two-entry queue for the back end, which takes one
// burst at a time: reference and unit multiplies, a voltage division, the
// offset from mid supply, a slope multiply, an absolute value and a Nernst
// division, both divisions at two quotient bits per cycle, then the pH offset
// and saturation. The input stalls only on the last sample of a burst while
// the queue is full. A burst with no valid sample, or with fewer than
// min_valid, gives status 1 with zero pH and voltage. Registers should be
// written only while no burst is in flight.
module oversampled_adc_to_ph_core #(
  parameter int SAMPLES_PER_READING = ohp_pkg::SAMPLES_PER_READING_DEF,
  parameter int ADC_FULL_SCALE      = ohp_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  ohp_chan_if.sink                     sample_in,
  ohp_chan_if.source                   reading_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ohp_pkg::APB_AW-1:0]   paddr,
  input  logic [ohp_pkg::APB_DW-1:0]   pwdata,
  output logic [ohp_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  ohp_pkg::cfg_t      cfg;
  ohp_pkg::reg_index_t reg_index;
  logic               cfg_write;

  logic               push;
  ohp_pkg::burst_t    push_data;
  logic               q_full;
  logic               pop;
  logic               head_valid;
  ohp_pkg::burst_t    head_data;

  assign pready    = 1'b1;
  assign reg_index = ohp_pkg::reg_index_t'(paddr[ohp_pkg::APB_AW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ph_offset_q16    <= ohp_pkg::PH_OFFSET_RST;
      cfg.ph_slope_q16     <= ohp_pkg::PH_SLOPE_RST;
      cfg.nernst_uv_per_ph <= ohp_pkg::NERNST_RST;
      cfg.reference_mv     <= ohp_pkg::REFERENCE_RST;
      cfg.min_valid        <= ohp_pkg::MIN_VALID_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        ohp_pkg::REG_PH_OFFSET: cfg.ph_offset_q16    <= pwdata[ohp_pkg::Q16_W-1:0];
        ohp_pkg::REG_PH_SLOPE:  cfg.ph_slope_q16     <= pwdata[ohp_pkg::Q16_W-1:0];
        ohp_pkg::REG_NERNST:    cfg.nernst_uv_per_ph <= pwdata[ohp_pkg::NERN_W-1:0];
        ohp_pkg::REG_REFERENCE: cfg.reference_mv     <= pwdata[ohp_pkg::REF_W-1:0];
        ohp_pkg::REG_MIN_VALID: cfg.min_valid        <= pwdata[ohp_pkg::MINV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      ohp_pkg::REG_PH_OFFSET: prdata = ohp_pkg::APB_DW'(cfg.ph_offset_q16);
      ohp_pkg::REG_PH_SLOPE:  prdata = ohp_pkg::APB_DW'(cfg.ph_slope_q16);
      ohp_pkg::REG_NERNST:    prdata = ohp_pkg::APB_DW'(cfg.nernst_uv_per_ph);
      ohp_pkg::REG_REFERENCE: prdata = ohp_pkg::APB_DW'(cfg.reference_mv);
      ohp_pkg::REG_MIN_VALID: prdata = ohp_pkg::APB_DW'(cfg.min_valid);
      default:                prdata = '0;
    endcase
  end

  ohp_front #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_in),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ohp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  ohp_back #(
    .ADC_FULL_SCALE (ADC_FULL_SCALE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head_data   (head_data),
    .pop         (pop),
    .reading_out (reading_out)
  );

  // A finished burst is never offered to a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("burst pushed into a full queue");

  // The back end only takes a burst that is there.
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("burst popped from an empty queue");

  // A failed reading carries zero pH and zero voltage.
  assert property (@(posedge clk) disable iff (rst)
    (reading_out.valid && reading_out.data.status) |->
      (reading_out.data.ph_value_q16 == '0 && reading_out.data.voltage_uv == '0))
    else $error("failed reading with nonzero payload");

endmodule
